// File: src/sitrd_pkg.sv
// Shared constants and types for the signed integer to radix text converter.
package sitrd_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned CHAR_W           = 8;
  localparam int unsigned DIGIT_W          = 4;
  localparam int unsigned RADIX_W          = 5;
  localparam int unsigned MAX_BASE         = 16;
  localparam int unsigned MAX_DIGITS       = 32;
  localparam int unsigned COUNT_W          = 6;
  localparam int unsigned BITS_PER_CYCLE   = 8;
  localparam int unsigned CYCLES_PER_DIGIT = DATA_W / BITS_PER_CYCLE;
  localparam int unsigned PHASE_W          = 2;
  localparam int unsigned STACK_W          = MAX_DIGITS * DIGIT_W;
  localparam int unsigned ALPHA_W          = 64;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [CHAR_W-1:0]  MINUS_CODE      = 8'h2D;
  localparam logic [RADIX_W-1:0] BASE_RESET      = 5'd10;
  localparam logic [ALPHA_W-1:0] CHARS_LOW_RESET = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] CHARS_HI_RESET  = 64'h4645444342413938;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SIZE  = 2'd0,
    CFG_CHARS_LOW  = 2'd1,
    CFG_CHARS_HIGH = 2'd2
  } cfg_reg_t;

endpackage

// File: src/sitrd_ifs.sv
// Channel interfaces: input value, output characters and configuration writes.
interface sitrd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sitrd_pkg::DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitrd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sitrd_pkg::CHAR_W-1:0]  char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface sitrd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sitrd_pkg::CFG_IDX_W-1:0] index;
  logic [sitrd_pkg::ALPHA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/signed_int_to_radix_digits_core.sv
// Signed 32-bit integer to radix text converter, one character per output item.
//
// Channels: num carries one signed value per item; text returns its characters,
// most significant first, a minus sign ahead of a negative value, last_char set
// on the final character. cfg writes the radix (index 0) and the two halves of
// the 16-symbol alphabet (indexes 1 and 2); it is always ready, and the user
// must see that it is written only while the converter is idle; the block does
// not enforce this. A radix below 2 acts as 2, above 16 as 16. Timing: each
// digit comes out of a shared divider that consumes 8 dividend bits per cycle
// and runs over the whole magnitude for every digit; the characters then
// follow while text is ready. num is ready again once the last character is
// loaded into the output register, so the next item can enter while it waits.
// Reset restores the default radix 10 and alphabet "0123456789ABCDEF" and
// empties the output register. A stalled text channel holds its character
// and pauses emission; no item is lost or repeated.
module signed_int_to_radix_digits_core (
  input  logic        clk,
  input  logic        rst,
  sitrd_in_if.sink    num,
  sitrd_out_if.source text,
  sitrd_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t                                 state;
  logic [sitrd_pkg::RADIX_W-1:0]          base_size;
  logic [sitrd_pkg::ALPHA_W-1:0]          chars_low;
  logic [sitrd_pkg::ALPHA_W-1:0]          chars_high;
  logic [sitrd_pkg::RADIX_W-1:0]          radix;
  logic [sitrd_pkg::DATA_W-1:0]           mag;
  logic [sitrd_pkg::DIGIT_W-1:0]          rem;
  logic [sitrd_pkg::PHASE_W-1:0]          phase;
  logic [sitrd_pkg::COUNT_W-1:0]          ndig;
  logic [sitrd_pkg::STACK_W-1:0]          stack;
  logic                                   sign_pend;
  logic                                   out_valid;
  logic [sitrd_pkg::CHAR_W-1:0]           out_char;
  logic                                   out_last;

  logic [sitrd_pkg::RADIX_W-1:0]          radix_eff;
  logic [sitrd_pkg::DATA_W-1:0]           raw;
  logic [sitrd_pkg::DATA_W-1:0]           mag_next;
  logic [sitrd_pkg::DIGIT_W-1:0]          rem_next;
  logic [sitrd_pkg::BITS_PER_CYCLE-1:0]   qbits;
  logic [2*sitrd_pkg::ALPHA_W-1:0]        alphabet;
  logic [sitrd_pkg::CHAR_W-1:0]           top_symbol;
  logic                                   out_free;
  logic                                   out_load;
  logic                                   num_fire;

  assign num.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign num_fire   = num.valid && num.ready;
  assign out_free   = !out_valid || text.ready;
  assign out_load   = (state == ST_EMIT) && out_free;

  assign text.valid     = out_valid;
  assign text.char_code = out_char;
  assign text.last_char = out_last;

  assign raw = num.value;

  always_comb begin
    if (base_size < sitrd_pkg::RADIX_W'(2)) begin
      radix_eff = sitrd_pkg::RADIX_W'(2);
    end else if (base_size > sitrd_pkg::RADIX_W'(sitrd_pkg::MAX_BASE)) begin
      radix_eff = sitrd_pkg::RADIX_W'(sitrd_pkg::MAX_BASE);
    end else begin
      radix_eff = base_size;
    end
  end

  // Restoring division of eight dividend bits by the narrow radix per cycle.
  always_comb begin
    logic [sitrd_pkg::RADIX_W-1:0] r;
    r = {1'b0, rem};
    for (int j = 0; j < sitrd_pkg::BITS_PER_CYCLE; j++) begin
      r = {r[sitrd_pkg::RADIX_W-2:0], mag[sitrd_pkg::DATA_W-1-j]};
      if (r >= radix) begin
        r = r - radix;
        qbits[sitrd_pkg::BITS_PER_CYCLE-1-j] = 1'b1;
      end else begin
        qbits[sitrd_pkg::BITS_PER_CYCLE-1-j] = 1'b0;
      end
    end
    rem_next = r[sitrd_pkg::DIGIT_W-1:0];
    mag_next = {mag[sitrd_pkg::DATA_W-sitrd_pkg::BITS_PER_CYCLE-1:0], qbits};
  end

  assign alphabet   = {chars_high, chars_low};
  assign top_symbol = alphabet[{stack[sitrd_pkg::DIGIT_W-1:0], 3'b000} +: sitrd_pkg::CHAR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size  <= sitrd_pkg::BASE_RESET;
      chars_low  <= sitrd_pkg::CHARS_LOW_RESET;
      chars_high <= sitrd_pkg::CHARS_HI_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        sitrd_pkg::CFG_BASE_SIZE:  base_size  <= cfg.data[sitrd_pkg::RADIX_W-1:0];
        sitrd_pkg::CFG_CHARS_LOW:  chars_low  <= cfg.data;
        sitrd_pkg::CFG_CHARS_HIGH: chars_high <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      radix     <= sitrd_pkg::RADIX_W'(2);
      rem       <= '0;
      phase     <= '0;
      ndig      <= '0;
      sign_pend <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (num_fire) begin
            sign_pend <= raw[sitrd_pkg::DATA_W-1];
            mag       <= raw[sitrd_pkg::DATA_W-1] ? (~raw + 1'b1) : raw;
            radix     <= radix_eff;
            rem       <= '0;
            phase     <= '0;
            ndig      <= '0;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          mag   <= mag_next;
          phase <= phase + 1'b1;
          if (phase == sitrd_pkg::PHASE_W'(sitrd_pkg::CYCLES_PER_DIGIT - 1)) begin
            // A digit is complete: push it; the newest digit sits on top.
            stack <= {stack[sitrd_pkg::STACK_W-sitrd_pkg::DIGIT_W-1:0], rem_next};
            rem   <= '0;
            ndig  <= ndig + 1'b1;
            if (mag_next == '0 ||
                ndig == sitrd_pkg::COUNT_W'(sitrd_pkg::MAX_DIGITS - 1)) begin
              state <= ST_EMIT;
            end
          end else begin
            rem <= rem_next;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (sign_pend) begin
              out_char  <= sitrd_pkg::MINUS_CODE;
              out_last  <= 1'b0;
              sign_pend <= 1'b0;
            end else begin
              out_char <= top_symbol;
              out_last <= (ndig == sitrd_pkg::COUNT_W'(1));
              stack    <= {{sitrd_pkg::DIGIT_W{1'b0}},
                           stack[sitrd_pkg::STACK_W-1:sitrd_pkg::DIGIT_W]};
              ndig     <= ndig - 1'b1;
              if (ndig == sitrd_pkg::COUNT_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    radix >= sitrd_pkg::RADIX_W'(2) && radix <= sitrd_pkg::RADIX_W'(sitrd_pkg::MAX_BASE))
    else $error("latched radix out of range");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> {1'b0, rem} < radix)
    else $error("partial remainder not below radix");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    ndig <= sitrd_pkg::COUNT_W'(sitrd_pkg::MAX_DIGITS))
    else $error("digit count beyond stack depth");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    num_fire |=> state == ST_DIV && phase == '0 && ndig == '0)
    else $error("accepted item did not start division");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_free && !sign_pend && ndig == sitrd_pkg::COUNT_W'(1)
    |=> out_valid && out_last && state == ST_IDLE)
    else $error("final character not flagged");

endmodule
